/* rtl/core/rtpv_pkg.sv */
package rtpv_pkg;

  // field widths
  localparam int ID_W   = 6;
  localparam int POS_W  = 20;
  localparam int VEL_W  = 16;
  localparam int LIM_W  = 19;
  localparam int VAR_W  = 24;

  // configuration port
  localparam int CFG_IW = 4;
  localparam int CFG_DW = 20;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_X = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_OFFSET_Y = 4'd1;
  localparam logic [CFG_IW-1:0] CFG_NEAR     = 4'd2;
  localparam logic [CFG_IW-1:0] CFG_FAR      = 4'd3;

  localparam logic [LIM_W-1:0] NEAR_RST = 19'd2560;
  localparam logic [LIM_W-1:0] FAR_RST  = 19'd6400;

  localparam int POS_FRAC_BITS_DEF = 8;
  localparam int FIFO_DEPTH_DEF    = 4;

  // arithmetic widths
  localparam int LSQ_W       = 2 * LIM_W;
  localparam int SQ_W        = 2 * POS_W;
  localparam int RAD_SH      = 20;
  localparam int ROOT_W      = (SQ_W + RAD_SH) / 2;
  localparam int REM_W       = ROOT_W + 4;
  localparam int QUO_W       = 24;
  localparam int DREM_W      = ROOT_W + 1;
  localparam int DIV_INIT_SH = 8;
  localparam int ET_W        = 28;
  localparam int SUM30_W     = 30;
  localparam int SIG_W       = 28;
  localparam int SIGSQ_W     = 2 * SIG_W;
  localparam int RECIP3_SH   = 33;
  localparam int SIG_SAT_SUM = 805306368;

  localparam logic [QUO_W-1:0] ER_NEAR_Q24 = 24'd4194304;
  localparam logic [QUO_W-1:0] ER_FAR_Q24  = 24'd8388608;
  localparam logic [ET_W-1:0]  ET_WIDE_Q32   = 28'd149922641;
  localparam logic [ET_W-1:0]  ET_MID_Q32    = 28'd74961321;
  localparam logic [ET_W-1:0]  ET_NARROW_Q32 = 28'd37480660;
  localparam logic [31:0]      RECIP3        = 32'hAAAAAAAB;
  localparam logic [SIGSQ_W:0] VAR_RND       = (SIGSQ_W + 1)'(64'h80000000);
  localparam logic [VAR_W-1:0] VAR_MAX       = 24'hFFFFFF;

  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  typedef enum logic [1:0] {
    ET_WIDE,
    ET_MID,
    ET_NARROW
  } et_zone_t;

  typedef struct packed {
    logic signed [POS_W-1:0] off_x;
    logic signed [POS_W-1:0] off_y;
    logic [LSQ_W-1:0]        near_sq;
    logic [LSQ_W-1:0]        far_sq;
  } cfg_t;

  // one classified track, as queued between front and back
  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [POS_W-1:0]        ax;
    logic [POS_W-1:0]        ay;
    logic [SQ_W-1:0]         sq;
    logic                    er_far;
    et_zone_t                zone;
    logic signed [POS_W-1:0] aln_x;
    logic signed [POS_W-1:0] aln_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] acc_x;
    logic                    last;
  } trk_t;

  function automatic logic [ET_W-1:0] et_q32(et_zone_t z);
    logic [ET_W-1:0] v;
    case (z)
      ET_WIDE:   v = ET_WIDE_Q32;
      ET_MID:    v = ET_MID_Q32;
      ET_NARROW: v = ET_NARROW_Q32;
      default:   v = ET_NARROW_Q32;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/rtpv_if.sv */
interface rtpv_in_if import rtpv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         trk_id;
  logic signed [POS_W-1:0] point0_x;
  logic signed [POS_W-1:0] point0_y;
  logic signed [POS_W-1:0] point1_y;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] accel_x;
  logic                    last_track;

  modport source (output valid, trk_id, point0_x, point0_y, point1_y, vel_x, vel_y,
                  accel_x, last_track, input ready);
  modport sink   (input valid, trk_id, point0_x, point0_y, point1_y, vel_x, vel_y,
                  accel_x, last_track, output ready);
endinterface

interface rtpv_out_if import rtpv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ID_W-1:0]         out_id;
  logic signed [POS_W-1:0] aligned_x;
  logic signed [POS_W-1:0] aligned_y;
  logic [VAR_W-1:0]        variance_x;
  logic [VAR_W-1:0]        variance_y;
  logic signed [VEL_W-1:0] out_vel_x;
  logic signed [VEL_W-1:0] out_vel_y;
  logic signed [VEL_W-1:0] out_accel_x;
  logic                    out_last;

  modport source (output valid, out_id, aligned_x, aligned_y, variance_x, variance_y,
                  out_vel_x, out_vel_y, out_accel_x, out_last, input ready);
  modport sink   (input valid, out_id, aligned_x, aligned_y, variance_x, variance_y,
                  out_vel_x, out_vel_y, out_accel_x, out_last, output ready);
endinterface

interface rtpv_cfg_if import rtpv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/rtpv_cfg.sv */
module rtpv_cfg import rtpv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rtpv_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  logic signed [POS_W-1:0] off_x_r, off_y_r;
  logic [LIM_W-1:0]        near_r, far_r;
  logic [LSQ_W-1:0]        near_sq_r, far_sq_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r   <= '0;
      off_y_r   <= '0;
      near_r    <= NEAR_RST;
      far_r     <= FAR_RST;
      near_sq_r <= LSQ_W'(NEAR_RST) * LSQ_W'(NEAR_RST);
      far_sq_r  <= LSQ_W'(FAR_RST) * LSQ_W'(FAR_RST);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_OFFSET_X: off_x_r <= cfg_ch.data[POS_W-1:0];
          CFG_OFFSET_Y: off_y_r <= cfg_ch.data[POS_W-1:0];
          CFG_NEAR:     near_r  <= cfg_ch.data[LIM_W-1:0];
          CFG_FAR:      far_r   <= cfg_ch.data[LIM_W-1:0];
          default: begin
          end
        endcase
      end
      // squared limits follow the bounds in the next cycle
      near_sq_r <= near_r * near_r;
      far_sq_r  <= far_r * far_r;
    end
  end

  assign cfg.off_x   = off_x_r;
  assign cfg.off_y   = off_y_r;
  assign cfg.near_sq = near_sq_r;
  assign cfg.far_sq  = far_sq_r;

endmodule

/* rtl/core/rtpv_front.sv */
module rtpv_front import rtpv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rtpv_in_if.sink  in_ch,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output trk_t     push_word
);

  function automatic logic signed [POS_W-1:0] sat_add(logic signed [POS_W-1:0] a,
                                                      logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    if (s[POS_W] != s[POS_W-1]) return s[POS_W] ? POS_MIN : POS_MAX;
    return s[POS_W-1:0];
  endfunction

  logic              adv;
  logic              v1_r, v2_r, v3_r;
  trk_t              s1_r, s2_r, s3_r;
  trk_t              s1_nxt, s3_nxt;
  logic [SQ_W-1:0]   ax2_r, ay2_r;
  logic [POS_W:0]    ysum;
  logic [POS_W-1:0]  y;

  // hold everything while the queue is full
  assign adv         = !q_full;
  assign in_ch.ready = adv;
  assign push        = v3_r && adv;
  assign push_word   = s3_r;

  always_comb begin
    ysum = {in_ch.point0_y[POS_W-1], in_ch.point0_y} +
           {in_ch.point1_y[POS_W-1], in_ch.point1_y};
    y    = ysum[POS_W:1];
    s1_nxt        = '0;
    s1_nxt.id     = in_ch.trk_id;
    s1_nxt.ax     = in_ch.point0_x[POS_W-1] ? (~in_ch.point0_x + 1'b1) : in_ch.point0_x;
    s1_nxt.ay     = y[POS_W-1] ? (~y + 1'b1) : y;
    s1_nxt.aln_x  = sat_add(in_ch.point0_x, cfg.off_x);
    s1_nxt.aln_y  = sat_add(y, cfg.off_y);
    s1_nxt.vel_x  = in_ch.vel_x;
    s1_nxt.vel_y  = in_ch.vel_y;
    s1_nxt.acc_x  = in_ch.accel_x;
    s1_nxt.last   = in_ch.last_track;
  end

  always_comb begin
    s3_nxt        = s2_r;
    s3_nxt.sq     = ax2_r + ay2_r;
    s3_nxt.er_far = s3_nxt.sq > SQ_W'(cfg.far_sq);
    if (s3_nxt.sq <= SQ_W'(cfg.near_sq)) begin
      s3_nxt.zone = ET_WIDE;
    end else if (s3_nxt.sq < SQ_W'(cfg.far_sq)) begin
      s3_nxt.zone = ET_MID;
    end else begin
      s3_nxt.zone = ET_NARROW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s1_r;
      ax2_r <= s1_r.ax * s1_r.ax;
      ay2_r <= s1_r.ay * s1_r.ay;
      s3_r  <= s3_nxt;
    end
  end

endmodule

/* rtl/core/rtpv_fifo.sv */
module rtpv_fifo import rtpv_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  trk_t push_word,
  output logic full,
  input  logic take,
  output logic head_valid,
  output trk_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trk_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            head_valid_r;
  trk_t            head_r;
  logic            load;

  assign full       = count_r == CW'(DEPTH);
  assign load       = (count_r != '0) && (!head_valid_r || take);
  assign head_valid = head_valid_r;
  assign head       = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
      head_valid_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (load) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + CW'(push) - CW'(load);
      if (load) begin
        head_valid_r <= 1'b1;
      end else if (take) begin
        head_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_word;
    if (load) head_r <= mem[rd_ptr_r];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("word pushed into full queue");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid_r && !take) |=> (head_valid_r && $stable(head_r)))
    else $error("waiting head word changed");

endmodule

/* rtl/core/rtpv_back.sv */
module rtpv_back import rtpv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  trk_t        head,
  output logic        take,
  rtpv_out_if.source  out_ch
);

  localparam int NSQ   = ROOT_W;
  localparam int NDV   = QUO_W;
  localparam int P1    = NSQ + NDV + 1;
  localparam int NST   = P1 + 3;
  localparam int BT_SH = POS_FRAC_BITS_DEF + 8;
  localparam int PROD_W = POS_W + ET_W;
  localparam int BT_W  = PROD_W - BT_SH;
  localparam int SUM_W = (BT_W + 1 > SUM30_W + 1) ? BT_W + 1 : SUM30_W + 1;
  localparam int RP_W  = SUM30_W + 32;

  logic              adv;
  logic [NST-1:0]    v_r;
  trk_t              pl_r [NST];
  logic [BT_W-1:0]   bx_r [P1];
  logic [BT_W-1:0]   by_r [P1];
  logic [PROD_W-1:0] bx_prod, by_prod;
  logic [ET_W-1:0]   et;

  logic [ROOT_W-1:0] sroot_r [1:NSQ];
  logic [REM_W-1:0]  srem_r  [1:NSQ];
  logic [ROOT_W-1:0] droot_r [1:NDV];
  logic [DREM_W-1:0] xr_r    [1:NDV];
  logic [DREM_W-1:0] yr_r    [1:NDV];
  logic [QUO_W-1:0]  xq_r    [1:NDV];
  logic [QUO_W-1:0]  yq_r    [1:NDV];

  logic                out_valid_r;
  trk_t                out_pl_r;
  logic [VAR_W-1:0]    var_r [2];

  // advance the whole pipe unless the output word is stalled
  assign adv  = !out_valid_r || out_ch.ready;
  assign take = head_valid && adv;

  always_comb begin
    et      = et_q32(head.zone);
    bx_prod = head.ay * et;
    by_prod = head.ax * et;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[NST-2:0], head_valid};
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= head;
      bx_r[0] <= bx_prod[PROD_W-1:BT_SH];
      by_r[0] <= by_prod[PROD_W-1:BT_SH];
      for (int i = 1; i < NST; i++) pl_r[i] <= pl_r[i-1];
      for (int i = 1; i < P1; i++) begin
        bx_r[i] <= bx_r[i-1];
        by_r[i] <= by_r[i-1];
      end
    end
  end

  // square root of sq * 2^RAD_SH, one root bit per stage
  for (genvar s = 1; s <= NSQ; s++) begin : g_sq
    localparam int K = NSQ - s;
    logic [ROOT_W-1:0] rin;
    logic [REM_W-1:0]  remin, sh, trial;
    logic [1:0]        pr;
    if (s == 1) begin : g_first
      assign rin   = '0;
      assign remin = '0;
    end else begin : g_next
      assign rin   = sroot_r[s-1];
      assign remin = srem_r[s-1];
    end
    if (K >= RAD_SH / 2) begin : g_bits
      assign pr = pl_r[s-1].sq[2*K-RAD_SH+1 -: 2];
    end else begin : g_zero
      assign pr = 2'b00;
    end
    assign sh    = {remin[REM_W-3:0], pr};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, rin, 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sh >= trial) begin
          srem_r[s]  <= sh - trial;
          sroot_r[s] <= {rin[ROOT_W-2:0], 1'b1};
        end else begin
          srem_r[s]  <= sh;
          sroot_r[s] <= {rin[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // range terms: restoring division by the root, one quotient bit per stage
  for (genvar d = 1; d <= NDV; d++) begin : g_dv
    logic [ROOT_W-1:0] rt;
    logic [DREM_W-1:0] xin, yin, xsh, ysh;
    logic [QUO_W-1:0]  xqin, yqin;
    if (d == 1) begin : g_first
      trk_t p;
      assign p    = pl_r[NSQ];
      assign rt   = sroot_r[NSQ];
      assign xin  = p.er_far ? (DREM_W'(p.ax) << (DIV_INIT_SH + 1))
                             : (DREM_W'(p.ax) << DIV_INIT_SH);
      assign yin  = p.er_far ? (DREM_W'(p.ay) << (DIV_INIT_SH + 1))
                             : (DREM_W'(p.ay) << DIV_INIT_SH);
      assign xqin = '0;
      assign yqin = '0;
    end else begin : g_next
      assign rt   = droot_r[d-1];
      assign xin  = xr_r[d-1];
      assign yin  = yr_r[d-1];
      assign xqin = xq_r[d-1];
      assign yqin = yq_r[d-1];
    end
    assign xsh = {xin[DREM_W-2:0], 1'b0};
    assign ysh = {yin[DREM_W-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (adv) begin
        droot_r[d] <= rt;
        if (xsh >= DREM_W'(rt)) begin
          xr_r[d] <= xsh - DREM_W'(rt);
          xq_r[d] <= {xqin[QUO_W-2:0], 1'b1};
        end else begin
          xr_r[d] <= xsh;
          xq_r[d] <= {xqin[QUO_W-2:0], 1'b0};
        end
        if (ysh >= DREM_W'(rt)) begin
          yr_r[d] <= ysh - DREM_W'(rt);
          yq_r[d] <= {yqin[QUO_W-2:0], 1'b1};
        end else begin
          yr_r[d] <= ysh;
          yq_r[d] <= {yqin[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // lane 0 is x, lane 1 is y
  logic                 zero_rng;
  logic [QUO_W-1:0]     lq [2];
  logic [BT_W-1:0]      lb [2];
  logic [SUM_W-1:0]     lsum [2];
  logic [SUM30_W-1:0]   ssum_r [2];
  logic                 big1_r [2], big2_r [2], big3_r [2];
  logic [RP_W-1:0]      rprod [2];
  logic [SIG_W-1:0]     sig_r [2];
  logic [SIGSQ_W-1:0]   sigsq_r [2];
  logic [SIGSQ_W:0]     rnd [2];
  logic [VAR_W:0]       vq [2];
  logic [VAR_W-1:0]     var_nxt [2];

  always_comb begin
    // zero range: bearing 0, so x carries the whole range error
    zero_rng = pl_r[P1-1].sq == '0;
    lq[0] = zero_rng ? (pl_r[P1-1].er_far ? ER_FAR_Q24 : ER_NEAR_Q24) : xq_r[NDV];
    lq[1] = zero_rng ? '0 : yq_r[NDV];
    lb[0] = bx_r[P1-1];
    lb[1] = by_r[P1-1];
    for (int l = 0; l < 2; l++) begin
      lsum[l]    = SUM_W'(lq[l]) + SUM_W'(lb[l]);
      rprod[l]   = ssum_r[l] * RECIP3;
      rnd[l]     = {1'b0, sigsq_r[l]} + VAR_RND;
      vq[l]      = rnd[l][SIGSQ_W -: VAR_W + 1];
      var_nxt[l] = (big3_r[l] || vq[l] > {1'b0, VAR_MAX}) ? VAR_MAX : vq[l][VAR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        big1_r[l]  <= lsum[l] >= SUM_W'(SIG_SAT_SUM);
        ssum_r[l]  <= lsum[l][SUM30_W-1:0];
        big2_r[l]  <= big1_r[l];
        sig_r[l]   <= rprod[l][RECIP3_SH +: SIG_W];
        big3_r[l]  <= big2_r[l];
        sigsq_r[l] <= sig_r[l] * sig_r[l];
        var_r[l]   <= var_nxt[l];
      end
      out_pl_r <= pl_r[NST-1];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_id      = out_pl_r.id;
  assign out_ch.aligned_x   = out_pl_r.aln_x;
  assign out_ch.aligned_y   = out_pl_r.aln_y;
  assign out_ch.variance_x  = var_r[0];
  assign out_ch.variance_y  = var_r[1];
  assign out_ch.out_vel_x   = out_pl_r.vel_x;
  assign out_ch.out_vel_y   = out_pl_r.vel_y;
  assign out_ch.out_accel_x = out_pl_r.acc_x;
  assign out_ch.out_last    = out_pl_r.last;

endmodule

/* rtl/core/radar_track_position_variance_unit.sv */
// Throughput: one track word per cycle unless the output stalls, set by the 30-stage
//   square root and the two 24-stage range dividers, each retiring one bit per stage.
// Reset: rst_n synchronous, active low; clears all valid bits and the queue count and
//   loads the register defaults (offsets 0, near 10 m, far 25 m). No clearing pass.
module radar_track_position_variance_unit import rtpv_pkg::*; #(
  parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rtpv_in_if.sink     in_ch,
  rtpv_out_if.source  out_ch,
  rtpv_cfg_if.sink    cfg_ch
);

  // Register file: offsets and range bounds. The bounds are kept squared so the
  // front can classify a track by comparing x^2 + y^2 directly, with no root.
  cfg_t cfg;

  rtpv_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Front: take a word, form the midpoint y, magnitudes, aligned positions and the
  // squared range, then pick the range error and bearing error zone. Three stages;
  // hold while the queue is full.
  logic q_full;
  logic push;
  trk_t push_word;

  rtpv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  // Queue between front and back, with a registered head word. It lets the front keep
  // taking words while the output side stalls, until the queue is full.
  logic head_valid;
  logic take;
  trk_t head;

  rtpv_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .take       (take),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: bearing products, pipelined root of the scaled range, range-term dividers,
  // divide by three via reciprocal, square and round to Q.16 with saturation. The
  // whole pipe advances together whenever the output register is free or drained.
  rtpv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

/* tb/sv/radar_track_position_variance_unit_tb.sv */
`timescale 1ns / 100ps

module radar_track_position_variance_unit_tb;
  import rtpv_pkg::*;

  localparam int SHIFT_ET = POS_FRAC_BITS_DEF + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS = 900;
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED = 4'd9;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] p0x;
    logic signed [POS_W-1:0] p0y;
    logic signed [POS_W-1:0] p1y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] ax;
    logic                    last;
  } track_word_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] aln_x;
    logic signed [POS_W-1:0] aln_y;
    logic [VAR_W-1:0]        var_x;
    logic [VAR_W-1:0]        var_y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] ax;
    logic                    last;
  } track_result_t;

  // one directed row: a track plus, where obvious, the typed-in variances
  typedef struct {
    track_word_t     trk;
    bit              fixed;
    logic [VAR_W-1:0] vx_fixed;
    logic [VAR_W-1:0] vy_fixed;
  } directed_row_t;

  logic clk;
  logic rst_n;

  rtpv_in_if  in_ch();
  rtpv_out_if out_ch();
  rtpv_cfg_if cfg_ch();

  radar_track_position_variance_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // shadow copy of the register file
  logic signed [POS_W-1:0] sh_off_x, sh_off_y;
  logic [LIM_W-1:0]        sh_near, sh_far;

  track_result_t pending_results[$];
  int  errors = 0;
  int  cycles = 0;
  int  results_seen = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  bit  hold_off_req = 0;
  bit  hold_off_done = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // global watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [VAR_W-1:0] sigma_to_var(logic [63:0] rt, logic [63:0] bt);
    logic [63:0] sig, v;
    sig = (rt + bt) / 3;
    if (sig >= (64'd1 << 28)) return VAR_MAX;
    v = (sig * sig + (64'd1 << 31)) >> 32;
    return (v > VAR_MAX) ? VAR_MAX : v[VAR_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
    if (v < longint'(POS_MIN)) return POS_MIN;
    if (v > longint'(POS_MAX)) return POS_MAX;
    return v[POS_W-1:0];
  endfunction

  // compute the aligned position and variances of one track
  function automatic track_result_t align_track(track_word_t t);
    track_result_t r;
    longint x, s, y;
    logic [63:0] mx, my, sq, nl2, fl2, er, et, rx, ry, bx, by, rr;
    x = longint'(t.p0x);
    s = longint'(t.p0y) + longint'(t.p1y);
    y = s >>> 1;  // arithmetic shift is floor division by two
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    sq = mx * mx + my * my;
    nl2 = 64'(sh_near) * 64'(sh_near);
    fl2 = 64'(sh_far) * 64'(sh_far);
    er = (sq <= fl2) ? 64'(ER_NEAR_Q24) : 64'(ER_FAR_Q24);
    if (sq <= nl2)      et = 64'(ET_WIDE_Q32);
    else if (sq < fl2)  et = 64'(ET_MID_Q32);
    else                et = 64'(ET_NARROW_Q32);
    if (sq == 0) begin
      // zero range: bearing taken as zero
      rx = er;
      ry = 0;
    end else begin
      rr = int_sqrt(sq << 20);
      rx = ((er * mx) << 10) / rr;
      ry = ((er * my) << 10) / rr;
    end
    bx = (my * et) >> SHIFT_ET;
    by = (mx * et) >> SHIFT_ET;
    r.id    = t.id;
    r.aln_x = clamp_pos(x + longint'(sh_off_x));
    r.aln_y = clamp_pos(y + longint'(sh_off_y));
    r.var_x = sigma_to_var(rx, bx);
    r.var_y = sigma_to_var(ry, by);
    r.vx = t.vx;
    r.vy = t.vy;
    r.ax = t.ax;
    r.last = t.last;
    return r;
  endfunction

  // receiver: random stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= 300;
      hold_off_done <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker: compare each result word with the oldest expectation
  always @(posedge clk) begin
    track_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_id, out_ch.aligned_x, out_ch.aligned_y, out_ch.variance_x,
              out_ch.variance_y, out_ch.out_vel_x, out_ch.out_vel_y, out_ch.out_accel_x,
              out_ch.out_last};
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %h actual %h", $time, want, got);
          if (got.var_x !== want.var_x)
            $display("%0t   variance_x expected %0d actual %0d", $time, want.var_x, got.var_x);
          if (got.var_y !== want.var_y)
            $display("%0t   variance_y expected %0d actual %0d", $time, want.var_y, got.var_y);
          errors <= errors + 1;
        end
      end
    end
  end

  // write one register; block must be idle
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_OFFSET_X: sh_off_x = val;
      CFG_OFFSET_Y: sh_off_y = val;
      CFG_NEAR:     sh_near  = val[LIM_W-1:0];
      CFG_FAR:      sh_far   = val[LIM_W-1:0];
      default: ;  // unknown index: ignored
    endcase
    @(negedge clk);
  endtask

  task automatic load_setting(int ox, int oy, int nl, int fl);
    write_reg(CFG_OFFSET_X, ox[CFG_DW-1:0]);
    write_reg(CFG_OFFSET_Y, oy[CFG_DW-1:0]);
    write_reg(CFG_NEAR, nl[CFG_DW-1:0]);
    write_reg(CFG_FAR, fl[CFG_DW-1:0]);
  endtask

  // offer one word, idle at the current rate, hold until accepted
  task automatic send_track(track_word_t t, track_result_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.trk_id     <= t.id;
    in_ch.point0_x   <= t.p0x;
    in_ch.point0_y   <= t.p0y;
    in_ch.point1_y   <= t.p1y;
    in_ch.vel_x      <= t.vx;
    in_ch.vel_y      <= t.vy;
    in_ch.accel_x    <= t.ax;
    in_ch.last_track <= t.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), r);
    @(negedge clk);
  endtask

  // wait until every expected result word has come, then drain the pipe
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(5))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return POS_W'($urandom_range(8000) - 4000);     // around the limits
      3: return POS_W'($urandom_range(200) - 100);       // very near
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic track_word_t rand_track();
    track_word_t t;
    t.id = ID_W'($urandom());
    t.p0x = rand_pos();
    t.p0y = rand_pos();
    t.p1y = ($urandom_range(3) == 0) ? rand_pos()
                                     : POS_W'(t.p0y + $urandom_range(64) - 32);
    t.vx = VEL_W'($urandom());
    t.vy = VEL_W'($urandom());
    t.ax = VEL_W'($urandom());
    t.last = 1'($urandom());
    return t;
  endfunction

  directed_row_t rows[$];

  task automatic add_row(track_word_t t, bit fx, int vxv, int vyv);
    directed_row_t d;
    d.trk = t;
    d.fixed = fx;
    d.vx_fixed = VAR_W'(vxv);
    d.vy_fixed = VAR_W'(vyv);
    rows.insert(rows.size(), d);
  endtask

  initial begin
    track_word_t t;
    track_result_t r;
    int phase;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.trk_id = '0;
    in_ch.point0_x = '0;
    in_ch.point0_y = '0;
    in_ch.point1_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.accel_x = '0;
    in_ch.last_track = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sh_off_x = '0;
    sh_off_y = '0;
    sh_near = NEAR_RST;
    sh_far = FAR_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table; zero range after reset: sigma_x = Er/3, var = 1/144 m^2 in Q.16
    add_row('{6'd0, 20'sd0, 20'sd0, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 1, 455, 0);
    add_row('{6'd63, POS_MAX, POS_MAX, POS_MAX, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1},
            0, 0, 0);
    add_row('{6'd1, POS_MIN, POS_MIN, POS_MIN, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0},
            0, 0, 0);
    add_row('{6'd2, POS_MAX, POS_MIN, POS_MIN, 16'sd1, -16'sd1, 16'sd0, 1'b1}, 0, 0, 0);
    add_row('{6'd3, -20'sd1, 20'sd1, -20'sd2, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 0, 0, 0);
    add_row('{6'd4, 20'sd2560, 20'sd0, 20'sd0, 16'sd5, 16'sd6, 16'sd7, 1'b0}, 0, 0, 0);
    add_row('{6'd5, 20'sd2561, 20'sd0, 20'sd0, 16'sd5, 16'sd6, 16'sd7, 1'b0}, 0, 0, 0);
    add_row('{6'd6, 20'sd6400, 20'sd0, 20'sd0, 16'sd5, 16'sd6, 16'sd7, 1'b0}, 0, 0, 0);
    add_row('{6'd7, 20'sd6401, 20'sd0, 20'sd0, 16'sd5, 16'sd6, 16'sd7, 1'b1}, 0, 0, 0);
    add_row('{6'd8, 20'sd0, -20'sd6400, -20'sd6400, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 0, 0, 0);
    add_row('{6'd9, 20'sd0, -20'sd1, 20'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}, 0, 0, 0);

    foreach (rows[i]) begin
      r = align_track(rows[i].trk);
      if (rows[i].fixed) begin
        r.var_x = rows[i].vx_fixed;
        r.var_y = rows[i].vy_fixed;
      end
      send_track(rows[i].trk, r);
    end
    drain();

    // position overflow and crossed limits, with an unknown index ignored
    load_setting(int'(POS_MAX), int'(POS_MIN), 6400, 2560);
    write_reg(CFG_UNMAPPED, 20'hABCDE);
    foreach (rows[i]) send_track(rows[i].trk, align_track(rows[i].trk));
    drain();

    // random part over several settings and idle phases
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_setting(0, 0, 2560, 6400);
        1: load_setting(int'(POS_MIN), int'(POS_MAX), 0, 0);
        2: load_setting($urandom(), $urandom(), 524287, 524287);
        3: load_setting($urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                        $urandom_range(4000), $urandom_range(8000));
        4: load_setting($urandom(), $urandom(), $urandom(), $urandom());
        default: load_setting(0, 0, 1, 524287);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      if (phase == 0) hold_off_req = 1;  // long stall so the block backs up
      repeat (RAND_ITEMS / 6) begin
        t = rand_track();
        send_track(t, align_track(t));
      end
      drain();  // sender pauses until all results are back
    end

    repeat (100) @(negedge clk);
    $display("covered %0d result words over directed extremes and six register settings",
             results_seen);
    $display("idle phases: none, sender 61%%, receiver 61%%, both 13%%, with a long hold-off");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
